>>> sv/ipru_pkg.sv
package ipru_pkg;

  localparam int unsigned MAX_SOURCE_WIDTH = 1024;
  localparam int unsigned MAX_SCALE        = 100;
  localparam int unsigned ADDR_W           = $clog2(MAX_SOURCE_WIDTH);

  localparam int unsigned SCALE_W = 7;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PULL = 1'b1
  } ipru_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } ipru_cfg_e;

  // Side information of one output pixel, decided when its read is issued.
  typedef struct packed {
    logic [1:0] pad;
    logic       row_end;
    logic       frame_end;
    logic       oob;
  } ipru_meta_t;

  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    r = s;
    if (s == '0) r = SCALE_W'(1);
    else if (s > SCALE_W'(MAX_SCALE)) r = SCALE_W'(MAX_SCALE);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] r;
    r = w;
    if (w == '0) r = DIM_W'(1);
    else if (w > DIM_W'(MAX_SOURCE_WIDTH)) r = DIM_W'(MAX_SOURCE_WIDTH);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
    return (h == '0) ? DIM_W'(1) : h;
  endfunction

  // Padding bytes for a row of w*s pixels of 3 bytes; only the low bits matter.
  function automatic logic [1:0] row_pad(input logic [1:0] w2, input logic [1:0] s2);
    logic [1:0] p;
    logic [1:0] b;
    p = 2'(w2 * s2);
    b = 2'(p * 2'd3);
    return 2'(2'd0 - b);
  endfunction

endpackage

>>> sv/ipru_if.sv
interface ipru_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, op, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, op, blue_in, green_in, red_in, output ready);
endinterface

interface ipru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [1:0] pad_after;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, blue_out, green_out, red_out, pad_after, row_end, frame_end,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, pad_after, row_end, frame_end,
                  output ready);
endinterface

>>> sv/ipru_row_ram.sv
module ipru_row_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 24,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ipru_seq.sv
module ipru_seq import ipru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic               op_i,
  input  logic [SCALE_W-1:0] scale_i,
  input  logic [DIM_W-1:0]   width_i,
  input  logic [DIM_W-1:0]   height_i,
  output logic               we_o,
  output logic [ADDR_W-1:0]  waddr_o,
  output logic               re_o,
  output logic [ADDR_W-1:0]  raddr_o,
  output ipru_meta_t         meta_o
);

  logic [DIM_W-1:0]   load_col_q, load_col_d;
  logic [DIM_W-1:0]   read_col_q, read_col_d;
  logic [SCALE_W-1:0] hrep_q, hrep_d;
  logic [SCALE_W-1:0] vrep_q, vrep_d;
  logic [DIM_W-1:0]   src_row_q, src_row_d;
  logic               row_ready_q, row_ready_d;

  always_comb begin
    load_col_d  = load_col_q;
    read_col_d  = read_col_q;
    hrep_d      = hrep_q;
    vrep_d      = vrep_q;
    src_row_d   = src_row_q;
    row_ready_d = row_ready_q;
    we_o        = 1'b0;
    waddr_o     = load_col_q[ADDR_W-1:0];
    re_o        = 1'b0;
    raddr_o     = read_col_q[ADDR_W-1:0];
    meta_o      = '0;
    meta_o.oob  = read_col_q >= DIM_W'(MAX_SOURCE_WIDTH);

    if (acc_i && (op_i == OP_LOAD) && !row_ready_q) begin
      we_o       = load_col_q < DIM_W'(MAX_SOURCE_WIDTH);
      load_col_d = load_col_q + DIM_W'(1);
      if (load_col_d >= width_i) begin
        load_col_d  = '0;
        row_ready_d = 1'b1;
      end
    end

    if (acc_i && (op_i == OP_PULL) && row_ready_q) begin
      re_o   = 1'b1;
      hrep_d = hrep_q + SCALE_W'(1);
      if (hrep_d >= scale_i) begin
        hrep_d     = '0;
        read_col_d = read_col_q + DIM_W'(1);
        if (read_col_d >= width_i) begin
          read_col_d     = '0;
          meta_o.row_end = 1'b1;
          meta_o.pad     = row_pad(width_i[1:0], scale_i[1:0]);
          vrep_d         = vrep_q + SCALE_W'(1);
          if (vrep_d >= scale_i) begin
            vrep_d      = '0;
            row_ready_d = 1'b0;
            src_row_d   = src_row_q + DIM_W'(1);
            if (src_row_d >= height_i) begin
              src_row_d        = '0;
              meta_o.frame_end = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q  <= '0;
      read_col_q  <= '0;
      hrep_q      <= '0;
      vrep_q      <= '0;
      src_row_q   <= '0;
      row_ready_q <= 1'b0;
    end else begin
      load_col_q  <= load_col_d;
      read_col_q  <= read_col_d;
      hrep_q      <= hrep_d;
      vrep_q      <= vrep_d;
      src_row_q   <= src_row_d;
      row_ready_q <= row_ready_d;
    end
  end

endmodule

>>> sv/integer_pixel_replication_upscaler.sv
// Nearest-neighbor integer upscaler for 24-bit pixels. Load items (op=0) write
// one source row of source_width pixels into a 1024-entry line buffer; once the
// row is complete, pull items (op=1) read it out scale_factor times, each pixel
// repeated scale_factor times, one result item per pull. The last pixel of each
// output row carries row_end and the zero-byte count that pads the row to a
// 4-byte boundary; the last pixel of the frame also carries frame_end. Loads
// sent while a row is still being read out are dropped, and pulls with no row
// loaded give no result. Rate: one item per cycle sustained; a pull's
// line-buffer read is registered as the pull is accepted and moves into the
// output register, where its result is offered, once that register is free.
// The input stalls only when the output register and the read in flight are
// both held by a stalled sink. Write configuration only while the block is
// idle; counters are kept across writes.
module integer_pixel_replication_upscaler import ipru_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  ipru_in_if.sink              pix_in,
  ipru_out_if.source           pix_out
);

  // configuration registers
  logic [SCALE_W-1:0] scale_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(1);
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SCALE_W-1:0] s_eff;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;

  assign s_eff = eff_scale(scale_q);
  assign w_eff = eff_width(width_q);
  assign h_eff = eff_height(height_q);

  // handshake: read in flight (pend) feeds the output register
  logic       pend_q, pend_d;
  ipru_meta_t pend_meta_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_acc;

  assign out_free     = !out_valid_q || pix_out.ready;
  assign pix_in.ready = !pend_q || out_free;
  assign in_acc       = pix_in.valid && pix_in.ready;

  // counters and line-buffer addressing
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  ipru_meta_t        rd_meta;

  ipru_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .op_i     (pix_in.op),
    .scale_i  (s_eff),
    .width_i  (w_eff),
    .height_i (h_eff),
    .we_o     (ram_we),
    .waddr_o  (ram_waddr),
    .re_o     (ram_re),
    .raddr_o  (ram_raddr),
    .meta_o   (rd_meta)
  );

  // writes and reads never share a cycle: row_ready gates one or the other
  ipru_row_ram #(
    .DEPTH (MAX_SOURCE_WIDTH),
    .WIDTH (PIX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic move;
  assign move = pend_q && out_free;

  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && pix_out.ready) out_valid_d = 1'b0;
    if (move) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (ram_re) pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  logic [PIX_W-1:0] out_pix_q;
  ipru_meta_t       out_meta_q;

  always_ff @(posedge clk_i) begin
    if (ram_re) pend_meta_q <= rd_meta;
    if (move) begin
      out_pix_q  <= pend_meta_q.oob ? '0 : ram_rdata;
      out_meta_q <= pend_meta_q;
    end
  end

  assign pix_out.valid     = out_valid_q;
  assign pix_out.blue_out  = out_pix_q[7:0];
  assign pix_out.green_out = out_pix_q[15:8];
  assign pix_out.red_out   = out_pix_q[23:16];
  assign pix_out.pad_after = out_meta_q.pad;
  assign pix_out.row_end   = out_meta_q.row_end;
  assign pix_out.frame_end = out_meta_q.frame_end;

  // checks
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line buffer written and read in one cycle");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> pend_q)
    else $error("issued read not tracked");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_free |=> pend_q && out_valid_q)
    else $error("pending pixel lost while output stalled");

  a_frame_on_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_meta_q.frame_end || out_meta_q.pad != 2'd0) |-> out_meta_q.row_end)
    else $error("frame end or padding off a row end");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import ipru_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS  = 310;
  localparam int unsigned SETTLE_CYCLES = 4;      // read pipe is two deep, plus margin
  localparam int unsigned HOLD_CYCLES   = 80;     // sink hold-off, long enough to fill the block
  localparam int unsigned WIDE_LOADS    = 60;     // loads into a saturated-width row
  localparam int unsigned END_WAIT      = 2000;
  localparam int unsigned CYCLE_LIMIT   = 20000;

  // One output pixel as it should leave the block.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       row_end;
    logic       frame_end;
  } pixel_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;

  ipru_in_if  pix_in_if ();
  ipru_out_if pix_out_if ();

  integer_pixel_replication_upscaler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_in_if),
    .pix_out    (pix_out_if)
  );

  // Shadow of the upscaler: registers, line buffer and the replication counters.
  logic [SCALE_W-1:0] cfg_scale  = SCALE_W'(1);
  logic [DIM_W-1:0]   cfg_width  = DIM_W'(1);
  logic [DIM_W-1:0]   cfg_height = DIM_W'(1);
  logic [PIX_W-1:0]   row_line [MAX_SOURCE_WIDTH];
  logic [DIM_W-1:0]   load_col  = '0;
  logic [DIM_W-1:0]   read_col  = '0;
  logic [DIM_W-1:0]   src_row   = '0;
  logic [SCALE_W-1:0] h_rep     = '0;
  logic [SCALE_W-1:0] v_rep     = '0;
  bit                 row_full  = 1'b0;

  pixel_result_t expected_pixels [$];

  int unsigned fail_count       = 0;
  int unsigned loads_taken      = 0;
  int unsigned loads_dropped    = 0;
  int unsigned empty_pulls      = 0;
  int unsigned pixels_predicted = 0;
  int unsigned pixels_checked   = 0;
  int unsigned frames_closed    = 0;
  int unsigned cycles           = 0;

  bit calm          = 1'b0;   // no idling on either side while set
  bit hold_off_req  = 1'b0;   // asks the sink to stall for HOLD_CYCLES

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Register values of zero act as one; scale and width saturate at the maxima.
  function automatic int unsigned live_scale();
    int unsigned v;
    v = cfg_scale;
    if (v == 0) v = 1;
    if (v > MAX_SCALE) v = MAX_SCALE;
    return v;
  endfunction

  function automatic int unsigned live_width();
    int unsigned v;
    v = cfg_width;
    if (v == 0) v = 1;
    if (v > MAX_SOURCE_WIDTH) v = MAX_SOURCE_WIDTH;
    return v;
  endfunction

  function automatic int unsigned live_height();
    return (cfg_height == '0) ? 1 : cfg_height;
  endfunction

  // Steps the shadow for one accepted item; a pull on a ready row queues a pixel.
  task automatic predict_upscale(input ipru_op_e op, input logic [7:0] b, g, r);
    int unsigned   s;
    int unsigned   w;
    int unsigned   h;
    int unsigned   row_bytes;
    logic [23:0]   px;
    pixel_result_t res;
    s = live_scale();
    w = live_width();
    h = live_height();
    if (op == OP_LOAD) begin
      // a row still being read out blocks new loads
      if (row_full) begin
        loads_dropped++;
        return;
      end
      loads_taken++;
      if (load_col < MAX_SOURCE_WIDTH) row_line[load_col] = {r, g, b};
      load_col = load_col + 1'b1;
      if (load_col >= w) begin
        load_col = '0;
        row_full = 1'b1;
      end
      return;
    end
    if (!row_full) begin
      empty_pulls++;
      return;
    end
    px = (read_col < MAX_SOURCE_WIDTH) ? row_line[read_col] : '0;
    res.blue      = px[7:0];
    res.green     = px[15:8];
    res.red       = px[23:16];
    res.pad       = 2'd0;
    res.row_end   = 1'b0;
    res.frame_end = 1'b0;
    // Limits are "reached or passed": a counter left above a lowered limit
    // closes its span on the next pull.
    h_rep = h_rep + 1'b1;
    if (h_rep >= s) begin
      h_rep    = '0;
      read_col = read_col + 1'b1;
      if (read_col >= w) begin
        read_col    = '0;
        res.row_end = 1'b1;
        // output row is 3*w*s bytes; pad it up to the next 4-byte boundary
        row_bytes   = 3 * w * s;
        res.pad     = 2'((4 - row_bytes % 4) % 4);
        v_rep       = v_rep + 1'b1;
        if (v_rep >= s) begin
          v_rep    = '0;
          row_full = 1'b0;
          src_row  = src_row + 1'b1;
          if (src_row >= h) begin
            src_row       = '0;
            res.frame_end = 1'b1;
            frames_closed++;
          end
        end
      end
    end
    expected_pixels.push_back(res);
    pixels_predicted++;
  endtask

  // --------------------------------------------------------------------------
  // Sink: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    pix_out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pix_out_if.ready <= 1'b0;
        for (int unsigned n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end
      pix_out_if.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && pix_out_if.valid && pix_out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("output pixel with none expected: b=%0d g=%0d r=%0d", pix_out_if.blue_out,
               pix_out_if.green_out, pix_out_if.red_out);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("blue_out",  want.blue,      pix_out_if.blue_out);
        check_field("green_out", want.green,     pix_out_if.green_out);
        check_field("red_out",   want.red,       pix_out_if.red_out);
        check_field("pad_after", want.pad,       pix_out_if.pad_after);
        check_field("row_end",   want.row_end,   pix_out_if.row_end);
        check_field("frame_end", want.frame_end, pix_out_if.frame_end);
        pixels_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Offers one item, with an occasional gap first, and returns at its acceptance.
  // Valid is left high so back-to-back items need no second assignment.
  task automatic send_item(input ipru_op_e op, input logic [7:0] b, g, r);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 3);
      pix_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in_if.valid    <= 1'b1;
    pix_in_if.op       <= op;
    pix_in_if.blue_in  <= b;
    pix_in_if.green_in <= g;
    pix_in_if.red_in   <= r;
    do @(posedge clk_i); while (!pix_in_if.ready);
    predict_upscale(op, b, g, r);
  endtask

  // Stops offering and waits out every pending pixel and the read pipe.
  task automatic wait_idle();
    pix_in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Block must be idle; the shadow register follows the write.
  task automatic write_reg(input ipru_cfg_e idx, input logic [DIM_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SCALE:  cfg_scale  = data[SCALE_W-1:0];
      CFG_WIDTH:  cfg_width  = data;
      CFG_HEIGHT: cfg_height = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned s, w, h);
    wait_idle();
    write_reg(CFG_SCALE,  DIM_W'(s));
    write_reg(CFG_WIDTH,  DIM_W'(w));
    write_reg(CFG_HEIGHT, DIM_W'(h));
  endtask

  // Loads one source row and pulls every copy of it. With shake set, stray
  // pulls/loads are mixed in and the scale may change while a row is out.
  task automatic run_row(input bit shake);
    while (!row_full) begin
      if (shake && $urandom_range(99) < 8)
        send_item(OP_PULL, rand_byte(), rand_byte(), rand_byte());
      else
        send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    end
    while (row_full) begin
      if (shake && $urandom_range(99) < 5)
        send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
      else
        send_item(OP_PULL, rand_byte(), rand_byte(), rand_byte());
      if (shake && row_full && $urandom_range(199) == 0) begin
        wait_idle();
        write_reg(CFG_SCALE, DIM_W'($urandom_range(1, 4)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings (1x1, scale 1): pull on empty buffer, dropped load, and
  // the extreme pixel values.
  task automatic test_reset_defaults();
    send_item(OP_PULL, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_LOAD, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
  endtask

  // All-zero registers behave as one.
  task automatic test_zero_registers();
    set_config(0, 0, 0);
    run_row(1'b0);
  endtask

  // Row widths giving padding counts of 2, 3 and 0.
  task automatic test_padding();
    for (int unsigned w = 2; w <= 4; w++) begin
      set_config(1, w, 1);
      run_row(1'b0);
    end
  endtask

  // Width lowered mid-load, scale lowered mid-readout, height lowered mid-frame.
  task automatic test_mid_frame_changes();
    set_config(3, 4, 2);
    repeat (3) send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    wait_idle();
    write_reg(CFG_WIDTH, DIM_W'(2));
    send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    repeat (4) send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_SCALE, DIM_W'(1));
    while (row_full) send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_HEIGHT, DIM_W'(1));
    run_row(1'b0);
  endtask

  // Saturating width register: a long load stretch without idling, then the
  // width lowered under the load column closes the row.
  task automatic test_wide_rows();
    calm = 1'b1;
    set_config(1, 2047, 1);
    repeat (WIDE_LOADS) send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    wait_idle();
    write_reg(CFG_WIDTH, DIM_W'(8));
    send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    while (row_full) send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    wait_idle();
    calm = 1'b0;
  endtask

  // Saturating scale on a one-pixel row: the row end falls on the hundredth
  // copy; the scale is then lowered under the repeat count.
  task automatic test_large_scale();
    set_config(127, 1, 1);
    send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    repeat (MAX_SCALE + 2) send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_SCALE, DIM_W'(1));
    while (row_full) send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
  endtask

  // Sink stalls long while pulls keep coming, then the sender drains.
  task automatic test_backpressure();
    set_config(2, 3, 1);
    while (!row_full) send_item(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
    hold_off_req = 1'b1;
    while (row_full) send_item(OP_PULL, 8'h00, 8'h00, 8'h00);
    wait_idle();
  endtask

  // Small random frames, settings changed at row boundaries, with noise.
  task automatic test_random_frames();
    int unsigned start;
    start = loads_taken + pixels_predicted;
    while (loads_taken + pixels_predicted - start < RANDOM_ITEMS) begin
      if ($urandom_range(2) == 0)
        set_config(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                   $urandom_range(0, 6), $urandom_range(0, 3));
      run_row(1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= CFG_SCALE;
    cfg_data_i         <= '0;
    pix_in_if.valid    <= 1'b0;
    pix_in_if.op       <= OP_LOAD;
    pix_in_if.blue_in  <= '0;
    pix_in_if.green_in <= '0;
    pix_in_if.red_in   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_registers();
    test_padding();
    test_mid_frame_changes();
    test_wide_rows();
    test_large_scale();
    test_backpressure();
    test_random_frames();

    // Drain with a bound; anything left over is a lost pixel.
    pix_in_if.valid <= 1'b0;
    for (int unsigned n = 0; n < END_WAIT && expected_pixels.size() != 0; n++)
      @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never came out", expected_pixels.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d loads (%0d dropped), %0d pulls on an empty buffer",
             loads_taken, loads_dropped, empty_pulls);
    $display("checked %0d output pixels over %0d completed frames, %0d cycles",
             pixels_checked, frames_closed, cycles);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/ipru_pkg.sv
sv/ipru_if.sv
sv/ipru_row_ram.sv
sv/ipru_seq.sv
sv/integer_pixel_replication_upscaler.sv
tb/sv/tb.sv
